// ===== design/caltrig_pkg.sv =====
// ----------------------------------------------------------------------------
// caltrig_pkg
// shared types, register codes and spec helpers of the calendar and periodic
// task trigger
// ----------------------------------------------------------------------------
package caltrig_pkg;

   localparam int DEF_NUM_SCHEDULED = 4;
   localparam int DEF_NUM_PERIODIC  = 4;

   localparam int SPEC_W      = 56;
   localparam int SPEC_REGS   = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int CHK_W       = 16;
   localparam int SLOT_IDX_W  = 3;   // wide enough for the largest slot count
   localparam int FLD_VAL_W   = 6;
   localparam int MOD_STEPS   = 6;   // one quotient bit per field value bit
   localparam int MOD_CNT_W   = 3;

   localparam logic [6:0] SPEC_UNSET = 7'd127;
   localparam logic [SPEC_W-1:0] SPEC_ALL_UNSET = {SPEC_W{1'b1}};

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SPEC_0    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEC_1    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEC_2    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEC_3    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PER_LOW   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PER_HIGH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CHECK_IVL = 3'd6;

   // spec field positions
   localparam logic [1:0] FLD_SECOND = 2'd0;
   localparam logic [1:0] FLD_MINUTE = 2'd1;
   localparam logic [1:0] FLD_HOUR   = 2'd2;
   localparam logic [1:0] FLD_DAY    = 2'd3;

   // fired kind codes
   localparam logic KIND_CAL = 1'b0;
   localparam logic KIND_PER = 1'b1;

   typedef struct packed {
      logic [31:0] uptime_ms;
      logic [31:0] unix_time;
      logic [5:0]  cal_second;
      logic [5:0]  cal_minute;
      logic [4:0]  cal_hour;
      logic [4:0]  cal_day;
   } req_type;

   typedef struct packed {
      logic       checked;
      logic       fired;
      logic       fired_kind;
      logic [1:0] fired_slot;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GATE,
      ST_CAL,
      ST_MOD,
      ST_CAL_NEXT,
      ST_PER,
      ST_PER_FIN,
      ST_DONE
   } state_type;

   function automatic logic [6:0] spec_fixed(input logic [SPEC_W-1:0] spec,
                                             input logic [1:0] f);
      return spec[14*f +: 7];
   endfunction

   // an interval of 127 or 0 both mean unset, 0 is returned for either
   function automatic logic [6:0] spec_interval(input logic [SPEC_W-1:0] spec,
                                                input logic [1:0] f);
      logic [6:0] iv;
      iv = spec[14*f + 7 +: 7];
      return (iv == SPEC_UNSET) ? 7'd0 : iv;
   endfunction

   function automatic logic field_set(input logic [SPEC_W-1:0] spec,
                                      input logic [1:0] f);
      return (spec_fixed(spec, f) != SPEC_UNSET) || (spec_interval(spec, f) != 7'd0);
   endfunction

   function automatic logic [31:0] periodic_interval(input logic [63:0] pair_low,
                                                     input logic [63:0] pair_high,
                                                     input logic [SLOT_IDX_W-1:0] idx);
      logic [31:0] iv;
      unique case (idx)
         3'd0:    iv = pair_low[31:0];
         3'd1:    iv = pair_low[63:32];
         3'd2:    iv = pair_high[31:0];
         3'd3:    iv = pair_high[63:32];
         default: iv = 32'd0;
      endcase
      return iv;
   endfunction

endpackage

// ===== design/calendar_and_periodic_task_trigger.sv =====
// ----------------------------------------------------------------------------
// calendar_and_periodic_task_trigger
// cron-style alarm scheduler: rate-gated scan of calendar slots, then of
// periodic slots, firing at most one slot per tick
// ----------------------------------------------------------------------------
//
//  channel   ports                      direction  moves
//  req       req_valid/ready/data       in         one tick beat (time stamp)
//  rsp       rsp_valid/ready/data       out        one result beat per tick
//  csr       csr_we/index/wdata         in         register write, no wait
//
//  scan: a tick beat passes the rate gate, then each calendar slot is worked
//    field by field, a field matched by interval going through the shared
//    bit-serial remainder unit, then, if no calendar slot fired, the periodic
//    slots; the result is handed over and the sequencer returns to idle before
//    the next beat is taken; a gated-off tick goes from the rate gate straight
//    to the result hand-over
//  one tick beat is worked at a time; req_ready is high only in the idle state
//  reset: synchronous, active high; clears the sequencer, the registers to
//    their reset values and all last-fire and last-check stamps at once
//  stalls: a result waits in the output register until rsp_ready; the
//    sequencer holds its finished result meanwhile
//
module calendar_and_periodic_task_trigger #(
   parameter int NUM_SCHEDULED = caltrig_pkg::DEF_NUM_SCHEDULED,
   parameter int NUM_PERIODIC  = caltrig_pkg::DEF_NUM_PERIODIC
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  caltrig_pkg::req_type                req_data,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output caltrig_pkg::rsp_type                rsp_data,
   // register write port
   input  logic                                csr_we,
   input  logic [caltrig_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [caltrig_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SCHED_W = (NUM_SCHEDULED > 1) ? $clog2(NUM_SCHEDULED) : 1;
   localparam int PER_W   = (NUM_PERIODIC > 1) ? $clog2(NUM_PERIODIC) : 1;
   localparam logic [SCHED_W-1:0] LAST_SCHED = SCHED_W'(NUM_SCHEDULED - 1);
   localparam logic [PER_W-1:0]   LAST_PER   = PER_W'(NUM_PERIODIC - 1);
   localparam logic [caltrig_pkg::MOD_CNT_W-1:0] LAST_MOD_STEP =
      caltrig_pkg::MOD_CNT_W'(caltrig_pkg::MOD_STEPS - 1);

   // configuration registers
   logic [caltrig_pkg::SPEC_W-1:0] spec_ff [caltrig_pkg::SPEC_REGS];
   logic [caltrig_pkg::SPEC_W-1:0] spec_in [caltrig_pkg::SPEC_REGS];
   logic [63:0]                    pair_low_ff, pair_low_in;
   logic [63:0]                    pair_high_ff, pair_high_in;
   logic [caltrig_pkg::CHK_W-1:0]  chk_ivl_ff, chk_ivl_in;

   // stamps
   logic [31:0] last_check_ff, last_check_in;
   logic [31:0] sched_last_ff [NUM_SCHEDULED];
   logic [31:0] sched_last_in [NUM_SCHEDULED];
   logic [31:0] per_tick_ff [NUM_PERIODIC];
   logic [31:0] per_tick_in [NUM_PERIODIC];

   // sequencer
   caltrig_pkg::state_type state_ff, state_in;
   logic [SCHED_W-1:0]     slot_ff, slot_in;
   logic [1:0]             field_ff, field_in;
   logic                   match_ff, match_in;
   logic [caltrig_pkg::MOD_CNT_W-1:0] bit_ff, bit_in;
   logic [6:0]             rem_ff, rem_in;
   logic [PER_W-1:0]       per_ff, per_in;
   logic                   best_valid_ff, best_valid_in;
   logic [PER_W-1:0]       best_ff, best_in;
   logic [31:0]            best_iv_ff, best_iv_in;

   // payload
   caltrig_pkg::req_type   req_ff, req_in;
   caltrig_pkg::rsp_type   res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   caltrig_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   // datapath
   logic [caltrig_pkg::SPEC_W-1:0] cur_spec;
   logic [6:0]                     fld_fx, fld_iv;
   logic                           slot_part;
   logic [caltrig_pkg::FLD_VAL_W-1:0] fld_val;
   logic [2:0]                     bit_pos;
   logic [7:0]                     rem_shift;
   logic [6:0]                     rem_next;
   logic [31:0]                    chk_elapsed;
   logic                           gate_pass;
   logic [31:0]                    per_iv;
   logic [31:0]                    per_elapsed;
   logic                           per_due;
   logic                           stamp_differs;
   logic                           out_free;

   // slots beyond the spec registers read as all unset
   always_comb begin
      logic [caltrig_pkg::SLOT_IDX_W-1:0] sidx;
      sidx = caltrig_pkg::SLOT_IDX_W'(slot_ff);
      if (sidx < caltrig_pkg::SLOT_IDX_W'(caltrig_pkg::SPEC_REGS)) begin
         cur_spec = spec_ff[sidx[1:0]];
      end else begin
         cur_spec = caltrig_pkg::SPEC_ALL_UNSET;
      end
   end

   assign fld_fx    = caltrig_pkg::spec_fixed(cur_spec, field_ff);
   assign fld_iv    = caltrig_pkg::spec_interval(cur_spec, field_ff);
   assign slot_part = caltrig_pkg::field_set(cur_spec, caltrig_pkg::FLD_SECOND) ||
                      caltrig_pkg::field_set(cur_spec, caltrig_pkg::FLD_MINUTE);

   always_comb begin
      unique case (field_ff)
         caltrig_pkg::FLD_SECOND: fld_val = req_ff.cal_second;
         caltrig_pkg::FLD_MINUTE: fld_val = req_ff.cal_minute;
         caltrig_pkg::FLD_HOUR:   fld_val = {1'b0, req_ff.cal_hour};
         caltrig_pkg::FLD_DAY:    fld_val = {1'b0, req_ff.cal_day};
      endcase
   end

   // restoring remainder, one value bit per cycle, msb first
   assign bit_pos   = 3'(LAST_MOD_STEP - bit_ff);
   assign rem_shift = {rem_ff, fld_val[bit_pos]};
   assign rem_next  = (rem_shift >= {1'b0, fld_iv}) ? 7'(rem_shift - {1'b0, fld_iv})
                                                    : rem_shift[6:0];

   assign chk_elapsed = req_ff.uptime_ms - last_check_ff;
   assign gate_pass   = !(chk_elapsed < {16'd0, chk_ivl_ff});

   assign per_iv      = caltrig_pkg::periodic_interval(pair_low_ff, pair_high_ff,
                                                       caltrig_pkg::SLOT_IDX_W'(per_ff));
   assign per_elapsed = req_ff.uptime_ms - per_tick_ff[per_ff];
   assign per_due     = (per_iv != 32'd0) && (per_elapsed > per_iv);

   assign stamp_differs = sched_last_ff[slot_ff] != req_ff.unix_time;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         caltrig_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = caltrig_pkg::ST_GATE;
            end
         end
         caltrig_pkg::ST_GATE: begin
            state_in = gate_pass ? caltrig_pkg::ST_CAL : caltrig_pkg::ST_DONE;
         end
         caltrig_pkg::ST_CAL: begin
            priority if (field_ff == caltrig_pkg::FLD_SECOND && !slot_part) begin
               state_in = caltrig_pkg::ST_CAL_NEXT;
            end else if (fld_fx == caltrig_pkg::SPEC_UNSET && fld_iv != 7'd0) begin
               state_in = caltrig_pkg::ST_MOD;
            end else begin
               state_in = caltrig_pkg::ST_CAL_NEXT;
            end
         end
         caltrig_pkg::ST_MOD: begin
            if (bit_ff == LAST_MOD_STEP) begin
               state_in = caltrig_pkg::ST_CAL_NEXT;
            end
         end
         caltrig_pkg::ST_CAL_NEXT: begin
            priority if (match_ff && field_ff == caltrig_pkg::FLD_DAY && stamp_differs) begin
               state_in = caltrig_pkg::ST_DONE;
            end else if (match_ff && field_ff != caltrig_pkg::FLD_DAY) begin
               state_in = caltrig_pkg::ST_CAL;
            end else if (slot_ff == LAST_SCHED) begin
               state_in = caltrig_pkg::ST_PER;
            end else begin
               state_in = caltrig_pkg::ST_CAL;
            end
         end
         caltrig_pkg::ST_PER: begin
            if (per_ff == LAST_PER) begin
               state_in = caltrig_pkg::ST_PER_FIN;
            end
         end
         caltrig_pkg::ST_PER_FIN: begin
            state_in = caltrig_pkg::ST_DONE;
         end
         caltrig_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = caltrig_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = caltrig_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and register updates
   always_comb begin
      spec_in       = spec_ff;
      pair_low_in   = pair_low_ff;
      pair_high_in  = pair_high_ff;
      chk_ivl_in    = chk_ivl_ff;
      last_check_in = last_check_ff;
      sched_last_in = sched_last_ff;
      per_tick_in   = per_tick_ff;
      slot_in       = slot_ff;
      field_in      = field_ff;
      match_in      = match_ff;
      bit_in        = bit_ff;
      rem_in        = rem_ff;
      per_in        = per_ff;
      best_valid_in = best_valid_ff;
      best_in       = best_ff;
      best_iv_in    = best_iv_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      // register writes, to be made only while idle; the block itself does not enforce it
      if (csr_we) begin
         unique case (csr_index)
            caltrig_pkg::REG_SPEC_0, caltrig_pkg::REG_SPEC_1,
            caltrig_pkg::REG_SPEC_2, caltrig_pkg::REG_SPEC_3: begin
               spec_in[csr_index[1:0]] = csr_wdata[caltrig_pkg::SPEC_W-1:0];
            end
            caltrig_pkg::REG_PER_LOW: begin
               pair_low_in = csr_wdata;
            end
            caltrig_pkg::REG_PER_HIGH: begin
               pair_high_in = csr_wdata;
            end
            caltrig_pkg::REG_CHECK_IVL: begin
               chk_ivl_in = csr_wdata[caltrig_pkg::CHK_W-1:0];
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         caltrig_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
            end
         end
         caltrig_pkg::ST_GATE: begin
            if (gate_pass) begin
               res_in.checked = 1'b1;
               last_check_in  = req_ff.uptime_ms;
               slot_in        = '0;
               field_in       = caltrig_pkg::FLD_SECOND;
            end
         end
         caltrig_pkg::ST_CAL: begin
            priority if (field_ff == caltrig_pkg::FLD_SECOND && !slot_part) begin
               match_in = 1'b0;
            end else if (fld_fx != caltrig_pkg::SPEC_UNSET) begin
               match_in = {1'b0, fld_val} == fld_fx;
            end else if (fld_iv != 7'd0) begin
               rem_in = '0;
               bit_in = '0;
            end else begin
               match_in = 1'b1;
            end
         end
         caltrig_pkg::ST_MOD: begin
            rem_in = rem_next;
            bit_in = bit_ff + 1'b1;
            if (bit_ff == LAST_MOD_STEP) begin
               match_in = rem_next == 7'd0;
            end
         end
         caltrig_pkg::ST_CAL_NEXT: begin
            priority if (match_ff && field_ff == caltrig_pkg::FLD_DAY && stamp_differs) begin
               sched_last_in[slot_ff] = req_ff.unix_time;
               res_in.fired      = 1'b1;
               res_in.fired_kind = caltrig_pkg::KIND_CAL;
               res_in.fired_slot = 2'(slot_ff);
            end else if (match_ff && field_ff != caltrig_pkg::FLD_DAY) begin
               field_in = field_ff + 1'b1;
            end else begin
               field_in = caltrig_pkg::FLD_SECOND;
               if (slot_ff == LAST_SCHED) begin
                  per_in        = '0;
                  best_valid_in = 1'b0;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         caltrig_pkg::ST_PER: begin
            // strictly greater keeps ties on the lower index
            if (per_due && (!best_valid_ff || per_iv > best_iv_ff)) begin
               best_valid_in = 1'b1;
               best_in       = per_ff;
               best_iv_in    = per_iv;
            end
            if (per_ff != LAST_PER) begin
               per_in = per_ff + 1'b1;
            end
         end
         caltrig_pkg::ST_PER_FIN: begin
            if (best_valid_ff) begin
               per_tick_in[best_ff] = req_ff.uptime_ms;
               res_in.fired      = 1'b1;
               res_in.fired_kind = caltrig_pkg::KIND_PER;
               res_in.fired_slot = 2'(best_ff);
            end
         end
         caltrig_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // control, configuration registers and stamps
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= caltrig_pkg::ST_IDLE;
         for (int i = 0; i < caltrig_pkg::SPEC_REGS; i++) begin
            spec_ff[i] <= caltrig_pkg::SPEC_ALL_UNSET;
         end
         pair_low_ff   <= '0;
         pair_high_ff  <= '0;
         chk_ivl_ff    <= '0;
         last_check_ff <= '0;
         for (int i = 0; i < NUM_SCHEDULED; i++) begin
            sched_last_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_PERIODIC; i++) begin
            per_tick_ff[i] <= '0;
         end
         slot_ff       <= '0;
         field_ff      <= caltrig_pkg::FLD_SECOND;
         match_ff      <= 1'b0;
         bit_ff        <= '0;
         per_ff        <= '0;
         best_valid_ff <= 1'b0;
         best_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         spec_ff       <= spec_in;
         pair_low_ff   <= pair_low_in;
         pair_high_ff  <= pair_high_in;
         chk_ivl_ff    <= chk_ivl_in;
         last_check_ff <= last_check_in;
         sched_last_ff <= sched_last_in;
         per_tick_ff   <= per_tick_in;
         slot_ff       <= slot_in;
         field_ff      <= field_in;
         match_ff      <= match_in;
         bit_ff        <= bit_in;
         per_ff        <= per_in;
         best_valid_ff <= best_valid_in;
         best_ff       <= best_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      res_ff      <= res_in;
      rem_ff      <= rem_in;
      best_iv_ff  <= best_iv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = state_ff == caltrig_pkg::ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a slot can only fire on a tick that passed the rate gate
   a_fire_needs_check: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.fired || rsp_data_ff.checked))
      else $error("fired without a check");

   // without a fire the kind and slot read as zero
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.fired) |->
         (rsp_data_ff.fired_kind == caltrig_pkg::KIND_CAL && rsp_data_ff.fired_slot == 2'd0))
      else $error("kind or slot set without a fire");

   // a taken beat closes the input until its result is handed over
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while busy");

   // the remainder unit never runs past its last step
   a_mod_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == caltrig_pkg::ST_MOD) |-> (bit_ff <= LAST_MOD_STEP))
      else $error("remainder step counter overran");

   // the remainder stays below the interval it is taken against
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == caltrig_pkg::ST_MOD && bit_ff != 3'd0) |-> (rem_ff < fld_iv))
      else $error("remainder out of range");
`endif

endmodule

// ===== bench/calendar_and_periodic_task_trigger_test.sv =====
// ----------------------------------------------------------------------------
// calendar_and_periodic_task_trigger_test
// self-checking bench: tick beats go in over valid/ready and result beats are
// checked against an in-bench prediction of the calendar and periodic scans,
// across directed ticks and random phases of well-formed clock sequences
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module calendar_and_periodic_task_trigger_test;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;   // long receiver hold-off
   localparam int TAIL_CYCLES = 200;   // above the worst scan of one tick
   localparam int PHASES      = 10;

   // one past the last register, the block must ignore it
   localparam logic [caltrig_pkg::CSR_IDX_W-1:0] REG_NONE = 3'd7;

   // ---------------------------------------------------------------------
   // scoreboard: mirrors registers and fire stamps, predicts each result
   // ---------------------------------------------------------------------
   class trigger_board;
      logic [caltrig_pkg::SPEC_W-1:0] spec_reg [caltrig_pkg::SPEC_REGS];
      logic [63:0]                    per_low;
      logic [63:0]                    per_high;
      logic [caltrig_pkg::CHK_W-1:0]  gate_ms;
      logic [31:0]                    last_check;
      logic [31:0]                    cal_last_fire [4];
      logic [31:0]                    per_last_tick [4];
      caltrig_pkg::rsp_type           due_results [$];
      int                             mismatches;

      function new();
         foreach (spec_reg[i]) spec_reg[i] = caltrig_pkg::SPEC_ALL_UNSET;
         per_low    = '0;
         per_high   = '0;
         gate_ms    = '0;
         last_check = '0;
         foreach (cal_last_fire[i]) cal_last_fire[i] = '0;
         foreach (per_last_tick[i]) per_last_tick[i] = '0;
         mismatches = 0;
      endfunction

      function void set_reg(input logic [caltrig_pkg::CSR_IDX_W-1:0] idx,
                            input logic [caltrig_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            caltrig_pkg::REG_SPEC_0:    spec_reg[0] = data[caltrig_pkg::SPEC_W-1:0];
            caltrig_pkg::REG_SPEC_1:    spec_reg[1] = data[caltrig_pkg::SPEC_W-1:0];
            caltrig_pkg::REG_SPEC_2:    spec_reg[2] = data[caltrig_pkg::SPEC_W-1:0];
            caltrig_pkg::REG_SPEC_3:    spec_reg[3] = data[caltrig_pkg::SPEC_W-1:0];
            caltrig_pkg::REG_PER_LOW:   per_low     = data;
            caltrig_pkg::REG_PER_HIGH:  per_high    = data;
            caltrig_pkg::REG_CHECK_IVL: gate_ms     = data[caltrig_pkg::CHK_W-1:0];
            default: ;
         endcase
      endfunction

      // works out the result of one accepted tick beat and queues it
      function void note_tick(input caltrig_pkg::req_type t);
         caltrig_pkg::rsp_type r;
         logic [5:0]  cal_val [4];
         logic [6:0]  fx;
         logic [6:0]  iv;
         logic [31:0] elapsed;
         logic [31:0] per_iv;
         logic [31:0] gap_ms;
         logic [31:0] best_iv;
         bit          part;
         bit          hit;
         bit          done;
         int          best;
         r          = '0;
         cal_val[0] = t.cal_second;
         cal_val[1] = t.cal_minute;
         cal_val[2] = {1'b0, t.cal_hour};
         cal_val[3] = {1'b0, t.cal_day};
         elapsed    = t.uptime_ms - last_check;
         done       = 1'b0;
         if (elapsed >= {16'd0, gate_ms}) begin
            r.checked  = 1'b1;
            last_check = t.uptime_ms;
            // calendar slots in index order
            for (int s = 0; s < caltrig_pkg::SPEC_REGS && !done; s++) begin
               part = 1'b0;
               hit  = 1'b1;
               for (int f = 0; f < 4; f++) begin
                  fx = spec_reg[s][14*f +: 7];
                  iv = spec_reg[s][14*f+7 +: 7];
                  if (iv == caltrig_pkg::SPEC_UNSET) iv = 7'd0;
                  if (f < 2 && (fx != caltrig_pkg::SPEC_UNSET || iv != 7'd0)) part = 1'b1;
                  if (fx != caltrig_pkg::SPEC_UNSET) begin
                     if ({1'b0, cal_val[f]} != fx) hit = 1'b0;
                  end else if (iv != 7'd0) begin
                     if ({1'b0, cal_val[f]} % iv != 7'd0) hit = 1'b0;
                  end
               end
               if (part && hit && cal_last_fire[s] != t.unix_time) begin
                  cal_last_fire[s] = t.unix_time;
                  r.fired      = 1'b1;
                  r.fired_kind = caltrig_pkg::KIND_CAL;
                  r.fired_slot = 2'(s);
                  done         = 1'b1;
               end
            end
            // periodic slots, longest due interval wins, ties to lower index
            if (!done) begin
               best    = -1;
               best_iv = '0;
               for (int p = 0; p < 4; p++) begin
                  per_iv = (p < 2) ? per_low[32*p +: 32] : per_high[32*(p-2) +: 32];
                  gap_ms = t.uptime_ms - per_last_tick[p];
                  if (per_iv != 0 && gap_ms > per_iv && (best < 0 || per_iv > best_iv)) begin
                     best    = p;
                     best_iv = per_iv;
                  end
               end
               if (best >= 0) begin
                  per_last_tick[best] = t.uptime_ms;
                  r.fired      = 1'b1;
                  r.fired_kind = caltrig_pkg::KIND_PER;
                  r.fired_slot = 2'(best);
               end
            end
         end
         due_results.push_back(r);
      endfunction

      // fields shown in order checked/fired/kind/slot
      function void check_result(input caltrig_pkg::rsp_type got);
         caltrig_pkg::rsp_type want;
         if (due_results.size() == 0) begin
            mismatches++;
            $display("%0t: expected no result beat, actual %0b/%0b/%0b/%0d",
                     $time, got.checked, got.fired, got.fired_kind, got.fired_slot);
            return;
         end
         want = due_results.pop_front();
         if (got.checked !== want.checked || got.fired !== want.fired ||
             got.fired_kind !== want.fired_kind || got.fired_slot !== want.fired_slot) begin
            mismatches++;
            $display("%0t: expected %0b/%0b/%0b/%0d, actual %0b/%0b/%0b/%0d",
                     $time, want.checked, want.fired, want.fired_kind, want.fired_slot,
                     got.checked, got.fired, got.fired_kind, got.fired_slot);
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // signals, all inputs known from time zero
   // ---------------------------------------------------------------------
   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   caltrig_pkg::req_type                req_data  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   caltrig_pkg::rsp_type                rsp_data;
   logic                                csr_we    = 1'b0;
   logic [caltrig_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [caltrig_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   trigger_board board = new();

   // idling, in cycles of a hundred
   int send_idle_pct = 20;
   int recv_idle_pct = 56;

   // hold-off requests to the receiver, one count per request
   int hold_asks = 0;

   // simulated wall clock feeding the well-formed tick sequences
   logic [31:0] up_now   = '0;
   logic [31:0] unix_now = '0;
   int          sec_now  = 0;
   int          min_now  = 0;
   int          hour_now = 0;
   int          day_now  = 1;

   calendar_and_periodic_task_trigger i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // offers one tick beat and holds it until the block takes it;
   // valid is left high so back-to-back beats keep it high without a gap
   task automatic send_tick(input caltrig_pkg::req_type t);
      req_valid <= 1'b1;
      req_data  <= t;
      do @(posedge clock); while (!req_ready);
      board.note_tick(t);
   endtask

   // write enable stays high, the caller drops it after the last write
   task automatic csr_write(input logic [caltrig_pkg::CSR_IDX_W-1:0] idx,
                            input logic [caltrig_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      board.set_reg(idx, data);
   endtask

   // every register once; junk above the narrower registers must be dropped
   task automatic apply_setting(input logic [caltrig_pkg::SPEC_W-1:0] s0,
                                input logic [caltrig_pkg::SPEC_W-1:0] s1,
                                input logic [caltrig_pkg::SPEC_W-1:0] s2,
                                input logic [caltrig_pkg::SPEC_W-1:0] s3,
                                input logic [63:0] pl, input logic [63:0] ph,
                                input logic [caltrig_pkg::CHK_W-1:0] min_gap);
      csr_write(caltrig_pkg::REG_SPEC_0, {8'($urandom), s0});
      csr_write(caltrig_pkg::REG_SPEC_1, {8'($urandom), s1});
      csr_write(caltrig_pkg::REG_SPEC_2, {8'($urandom), s2});
      csr_write(caltrig_pkg::REG_SPEC_3, {8'($urandom), s3});
      csr_write(caltrig_pkg::REG_PER_LOW, pl);
      csr_write(caltrig_pkg::REG_PER_HIGH, ph);
      csr_write(caltrig_pkg::REG_CHECK_IVL, {48'($urandom), min_gap});
      csr_we <= 1'b0;
   endtask

   // block must be idle before its registers change
   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (board.due_results.size() != 0);
   endtask

   function automatic caltrig_pkg::req_type tick_of(input logic [31:0] up,
                                                    input logic [31:0] unix,
                                                    input int s, input int m,
                                                    input int h, input int d);
      caltrig_pkg::req_type t;
      t.uptime_ms  = up;
      t.unix_time  = unix;
      t.cal_second = 6'(s);
      t.cal_minute = 6'(m);
      t.cal_hour   = 5'(h);
      t.cal_day    = 5'(d);
      return t;
   endfunction

   // one spec field: wildcard, zero interval, fixed near now, interval, or junk
   function automatic logic [13:0] pick_field(input int cur);
      logic [6:0] fx;
      logic [6:0] iv;
      fx = caltrig_pkg::SPEC_UNSET;
      iv = caltrig_pkg::SPEC_UNSET;
      case ($urandom_range(7))
         0, 1: ;
         2:    iv = 7'd0;
         3, 4: fx = 7'(cur + $urandom_range(2));
         5, 6: iv = 7'($urandom_range(6, 1));
         default: begin
            fx = 7'($urandom);
            iv = 7'($urandom);
         end
      endcase
      return {iv, fx};
   endfunction

   // next tick beat: mostly the wall clock moving on, sometimes pure noise
   function automatic caltrig_pkg::req_type next_tick(input bit noise);
      if (noise)
         return tick_of($urandom, $urandom, $urandom_range(59), $urandom_range(59),
                        $urandom_range(23), $urandom_range(31, 1));
      up_now += $urandom_range(24);
      if ($urandom_range(19) == 0) up_now += $urandom;
      case ($urandom_range(9))
         0: ;                                          // same second again
         1: unix_now += $urandom_range(5000, 2);       // skip, calendar untouched
         default: begin
            unix_now++;
            sec_now++;
            if (sec_now == 60) begin
               sec_now = 0;
               min_now++;
               if (min_now == 60) begin
                  min_now = 0;
                  hour_now++;
                  if (hour_now == 24) begin
                     hour_now = 0;
                     day_now  = (day_now == 31) ? 1 : day_now + 1;
                  end
               end
            end
         end
      endcase
      return tick_of(up_now, unix_now, sec_now, min_now, hour_now, day_now);
   endfunction

   // ---------------------------------------------------------------------
   // receiver: checks result beats, stalls at random or on a hold-off
   // ---------------------------------------------------------------------
   int hold_seen  = 0;
   int stall_left = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
         if (hold_asks != hold_seen) begin
            hold_seen  = hold_asks;
            stall_left = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog
   initial begin
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      logic [caltrig_pkg::SPEC_W-1:0] sp [caltrig_pkg::SPEC_REGS];
      logic [31:0]                    per [4];
      logic [caltrig_pkg::CHK_W-1:0]  min_gap;
      int                             count;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values: every tick checked, nothing fires; field extremes
      send_tick(tick_of(32'd0, 32'd0, 0, 0, 0, 1));
      send_tick(tick_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 59, 59, 23, 31));
      drain();

      // slot 0 fixed second, slot 1 minute interval and fixed hour,
      // slot 2 hour only (so it never takes part), slot 3 all fixed;
      // periodic 10, 20, 20, off; the unknown register must change nothing
      csr_write(REG_NONE, '1);
      apply_setting({42'h3FF_FFFF_FFFF, 14'h3F85},
                    {14'h3FFF, 14'h3F83, 14'h07FF, 14'h3FFF},
                    {14'h3FFF, 14'h3F80, 14'h3FFF, 14'h007F},
                    {14'h3F81, 14'h3F80, 14'h3F80, 14'h3F80},
                    {32'd20, 32'd10}, {32'd0, 32'd20}, 16'd0);
      send_tick(tick_of(32'd5, 32'd0, 5, 0, 0, 1));      // unix 0 before any fire
      send_tick(tick_of(32'd30, 32'd100, 5, 7, 9, 2));   // fixed second
      send_tick(tick_of(32'd31, 32'd100, 5, 30, 3, 2));  // once per second, slot 1 next
      send_tick(tick_of(32'd32, 32'd100, 5, 30, 3, 2));  // periodic tie
      send_tick(tick_of(32'd33, 32'd100, 5, 30, 3, 2));
      send_tick(tick_of(32'd34, 32'd100, 5, 30, 3, 2));
      send_tick(tick_of(32'd40, 32'd100, 5, 30, 3, 2));  // nothing due
      send_tick(tick_of(32'd41, 32'd101, 0, 0, 0, 1));   // all fields fixed
      send_tick(tick_of(32'd44, 32'd101, 0, 0, 0, 1));   // due only when past interval
      send_tick(tick_of(32'd45, 32'd101, 0, 0, 0, 1));
      drain();

      // widest rate gate with wrap of the uptime, periodic never due
      apply_setting('0, '0, '0, '0, '1, '1, 16'hFFFF);
      send_tick(tick_of(32'd45 + 32'hFFFE, 32'd102, 0, 0, 0, 1));
      send_tick(tick_of(32'd45 + 32'hFFFF, 32'd102, 0, 0, 0, 1));
      send_tick(tick_of(32'hFFFF_FFF0, 32'd103, 1, 1, 1, 1));
      send_tick(tick_of(32'h0000_0010, 32'd104, 2, 2, 2, 2));
      send_tick(tick_of(32'h0000_FFF0, 32'd105, 3, 3, 3, 3));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         // sender lighter than receiver, then the reverse, then flat out
         if (ph < 4) begin
            send_idle_pct = 20;
            recv_idle_pct = 56;
         end else if (ph < 7) begin
            send_idle_pct = 56;
            recv_idle_pct = 20;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end

         if (ph == 0) begin
            apply_setting('0, '0, '0, '0, '0, '0, '0);
            count = 25;
         end else if (ph == 1) begin
            apply_setting('1, '1, '1, '1, '1, '1, '1);
            count = 25;
         end else begin
            // fresh wall clock so fixed fields near now can match
            unix_now = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom);
            sec_now  = $urandom_range(59);
            min_now  = $urandom_range(59);
            hour_now = $urandom_range(23);
            day_now  = $urandom_range(31, 1);
            if ($urandom_range(3) == 0) up_now = 32'hFFFF_FF00 + $urandom_range(255);
            for (int s = 0; s < caltrig_pkg::SPEC_REGS; s++)
               sp[s] = ($urandom_range(7) == 0) ? 56'({$urandom, $urandom}) :
                       {pick_field(day_now), pick_field(hour_now),
                        pick_field(min_now), pick_field(sec_now)};
            for (int p = 0; p < 4; p++)
               case ($urandom_range(7))
                  0:       per[p] = '0;
                  1:       per[p] = $urandom;
                  default: per[p] = $urandom_range(60, 1);
               endcase
            if ($urandom_range(2) == 0) per[2] = per[0];   // equal intervals
            case ($urandom_range(5))
               0, 1, 2: min_gap = '0;
               3, 4:    min_gap = 16'($urandom_range(30, 1));
               default: min_gap = 16'($urandom);
            endcase
            apply_setting(sp[0], sp[1], sp[2], sp[3], {per[1], per[0]}, {per[3], per[2]},
                          min_gap);
            count = 75;
         end

         for (int n = 0; n < count; n++) begin
            // receiver holds off while ticks keep coming, block backs up
            if ((ph == 3 || ph == 8) && n == 30) hold_asks <= hold_asks + 1;
            // sender waits for every outstanding result beat
            if (ph == 5 && n == 40) drain();
            while ($urandom_range(99) < send_idle_pct) begin
               req_valid <= 1'b0;
               @(posedge clock);
            end
            send_tick(next_tick($urandom_range(9) == 0));
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
